// ----- hw/rtl/cwdu_pkg.sv -----
// ----------------------------------------------------------------------------
// cwdu_pkg
// Shared types and constants for the word divide unit: operand widths,
// operation codes, quotient limits and the state that one item carries
// down the divider pipeline.
// ----------------------------------------------------------------------------
package cwdu_pkg;

    localparam int CWDU_DIVIDEND_W     = 32;
    localparam int CWDU_DIVISOR_W      = 16;
    localparam int CWDU_BITS_PER_STAGE = 4;

    localparam logic CWDU_OP_DIVU = 1'b0;
    localparam logic CWDU_OP_DIVS = 1'b1;

    localparam logic [CWDU_DIVIDEND_W-1:0] CWDU_QMAX_POS = 32'h0000_7fff;
    localparam logic [CWDU_DIVIDEND_W-1:0] CWDU_QMAX_NEG = 32'h0000_8000;

    typedef struct packed {
        logic [CWDU_DIVISOR_W-1:0]  rem;
        logic [CWDU_DIVIDEND_W-1:0] sh;
        logic [CWDU_DIVISOR_W-1:0]  av;
        logic                       op;
        logic                       neg_q;
        logic                       neg_r;
        logic                       dz;
    } t_div_state;

endpackage

// ----- hw/rtl/cwdu_div_stage.sv -----
// ----------------------------------------------------------------------------
// cwdu_div_stage
// One register stage of the restoring divider. It retires a fixed number of
// quotient bits per item and holds its item while the next stage stalls.
// ----------------------------------------------------------------------------
module cwdu_div_stage #(
    parameter int BITS = cwdu_pkg::CWDU_BITS_PER_STAGE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  cwdu_pkg::t_div_state i_state,
    output logic                 o_valid,
    input  logic                 i_stall,
    output cwdu_pkg::t_div_state o_state
);
    import cwdu_pkg::*;

    t_div_state r_state;
    t_div_state n_state;
    logic       r_valid;

    always_comb begin
        logic [CWDU_DIVISOR_W:0] trial;
        logic                    qbit;
        n_state = i_state;
        for (int k = 0; k < BITS; k++) begin
            trial = {n_state.rem, n_state.sh[CWDU_DIVIDEND_W-1]};
            if (trial >= {1'b0, n_state.av}) begin
                trial = trial - {1'b0, n_state.av};
                qbit  = 1'b1;
            end else begin
                qbit  = 1'b0;
            end
            n_state.rem = trial[CWDU_DIVISOR_W-1:0];
            n_state.sh  = {n_state.sh[CWDU_DIVIDEND_W-2:0], qbit};
        end
    end

    assign o_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;

endmodule

// ----- hw/rtl/cpu_word_divide_unit.sv -----
// Throughput: one item per cycle while the output is not stalled; the divider is a
// chain of register stages, each retiring BITS_PER_STAGE quotient bits with its own
// compare and subtract. A stall holds only the stages that are full, so bubbles
// are squeezed out. Reset (synchronous, active low) clears every valid bit; the
// payload is not reset.
// ----------------------------------------------------------------------------
// cpu_word_divide_unit
// Pipelined 32 by 16 word divide, unsigned or signed, with the packed
// remainder and quotient and the V, C, N and Z flags of the item.
// ----------------------------------------------------------------------------
module cpu_word_divide_unit #(
    parameter int BITS_PER_STAGE = cwdu_pkg::CWDU_BITS_PER_STAGE
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_operation,
    input  logic [cwdu_pkg::CWDU_DIVIDEND_W-1:0] i_dividend,
    input  logic [cwdu_pkg::CWDU_DIVISOR_W-1:0]  i_divisor,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [cwdu_pkg::CWDU_DIVIDEND_W-1:0] o_packed_result,
    output logic                                 o_write_enable,
    output logic                                 o_overflow_flag,
    output logic                                 o_carry_flag,
    output logic                                 o_negative_flag,
    output logic                                 o_zero_flag,
    output logic                                 o_nz_update,
    output logic                                 o_divide_by_zero
);
    import cwdu_pkg::*;

    localparam int NSTAGES = CWDU_DIVIDEND_W / BITS_PER_STAGE;
    localparam int DW      = CWDU_DIVIDEND_W;
    localparam int VW      = CWDU_DIVISOR_W;

    t_div_state r_s0;
    t_div_state n_s0;
    logic       r_s0_valid;
    logic       s0_stall;

    t_div_state st_state [NSTAGES+1];
    logic       st_valid [NSTAGES+1];
    logic       st_stall [NSTAGES+1];

    logic          r_out_valid;
    logic [DW-1:0] r_packed;
    logic          r_we;
    logic          r_ovf;
    logic          r_neg;
    logic          r_zero;
    logic          r_upd;
    logic          r_dz;

    logic [DW-1:0] n_packed;
    logic          n_we;
    logic          n_ovf;
    logic          n_neg;
    logic          n_zero;
    logic          n_upd;
    logic          n_dz;

    // Operand conditioning: magnitudes and result signs.
    always_comb begin
        logic dvd_neg;
        logic dvs_neg;
        dvd_neg = (i_operation == CWDU_OP_DIVS) && i_dividend[DW-1];
        dvs_neg = (i_operation == CWDU_OP_DIVS) && i_divisor[VW-1];
        n_s0.rem   = '0;
        n_s0.sh    = dvd_neg ? (DW'(0) - i_dividend) : i_dividend;
        n_s0.av    = dvs_neg ? (VW'(0) - i_divisor) : i_divisor;
        n_s0.op    = i_operation;
        n_s0.neg_q = dvd_neg != dvs_neg;
        n_s0.neg_r = dvd_neg;
        n_s0.dz    = (i_divisor == '0);
    end

    assign o_stall = r_s0_valid && s0_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_s0 <= n_s0;
        end
    end

    assign st_state[0] = r_s0;
    assign st_valid[0] = r_s0_valid;
    assign s0_stall    = st_stall[0];

    for (genvar g = 0; g < NSTAGES; g++) begin : g_div
        cwdu_div_stage #(
            .BITS (BITS_PER_STAGE)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (st_valid[g]),
            .o_stall (st_stall[g]),
            .i_state (st_state[g]),
            .o_valid (st_valid[g+1]),
            .i_stall (st_stall[g+1]),
            .o_state (st_state[g+1])
        );
    end

    assign st_stall[NSTAGES] = r_out_valid && i_stall;

    // Sign correction, overflow check and flags.
    always_comb begin
        t_div_state    s;
        logic [DW-1:0] q;
        logic [VW-1:0] r;
        logic [VW-1:0] q16;
        logic [VW-1:0] r16;
        logic          ovf;
        s   = st_state[NSTAGES];
        q   = s.sh;
        r   = s.rem;
        if (s.op == CWDU_OP_DIVU) begin
            ovf = |q[DW-1:VW];
        end else if (s.neg_q) begin
            ovf = q > CWDU_QMAX_NEG;
        end else begin
            ovf = q > CWDU_QMAX_POS;
        end
        q16 = s.neg_q ? (VW'(0) - q[VW-1:0]) : q[VW-1:0];
        r16 = s.neg_r ? (VW'(0) - r) : r;
        n_dz     = s.dz;
        n_ovf    = !s.dz && ovf;
        n_we     = !s.dz && !ovf;
        n_upd    = n_we;
        n_packed = n_we ? {r16, q16} : '0;
        n_neg    = n_we && q16[VW-1];
        n_zero   = n_we && (q16 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!st_stall[NSTAGES]) begin
            r_out_valid <= st_valid[NSTAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (st_valid[NSTAGES] && !st_stall[NSTAGES]) begin
            r_packed <= n_packed;
            r_we     <= n_we;
            r_ovf    <= n_ovf;
            r_neg    <= n_neg;
            r_zero   <= n_zero;
            r_upd    <= n_upd;
            r_dz     <= n_dz;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_packed_result  = r_packed;
    assign o_write_enable   = r_we;
    assign o_overflow_flag  = r_ovf;
    assign o_carry_flag     = 1'b0;
    assign o_negative_flag  = r_neg;
    assign o_zero_flag      = r_zero;
    assign o_nz_update      = r_upd;
    assign o_divide_by_zero = r_dz;

`ifndef SYNTHESIS
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_write_enable, o_overflow_flag, o_divide_by_zero}) == 1)
        else $error("An item must write, overflow or divide by zero, exactly one of these.");

    a_upd_follows_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_nz_update == o_write_enable)
        else $error("N and Z must be updated exactly when the result is written.");

    a_quiet_when_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |->
            (o_packed_result == '0 && !o_negative_flag && !o_zero_flag))
        else $error("An item that writes nothing must carry a cleared result.");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s0_valid && r_out_valid && i_stall))
        else $error("The input may only stall when the pipeline holds items back.");
`endif

endmodule

// ----- dv/cpu_word_divide_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Word divide unit testbench
// Drives unsigned and signed 32 by 16 divides through the valid/stall
// channels with random gaps on both sides, and one long output hold-off that
// fills the pipeline. Each result is checked, field by field, against a
// predictor that applies truncating division, the 16-bit quotient limits and
// the zero divisor and overflow rules.
// ----------------------------------------------------------------------------
module cpu_word_divide_unit_tb;
    import cwdu_pkg::*;

    localparam int NUM_RANDOM     = 1000;
    localparam int MAX_GAP        = 14;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 400;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic                       op;
        logic [CWDU_DIVIDEND_W-1:0] dividend;
        logic [CWDU_DIVISOR_W-1:0]  divisor;
    } t_div_item;

    typedef struct packed {
        logic [CWDU_DIVIDEND_W-1:0] packed_result;
        logic                       write_enable;
        logic                       overflow_flag;
        logic                       carry_flag;
        logic                       negative_flag;
        logic                       zero_flag;
        logic                       nz_update;
        logic                       divide_by_zero;
    } t_div_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic                       i_operation;
    logic [CWDU_DIVIDEND_W-1:0] i_dividend;
    logic [CWDU_DIVISOR_W-1:0]  i_divisor;
    logic                       o_valid;
    logic                       i_stall;
    logic [CWDU_DIVIDEND_W-1:0] o_packed_result;
    logic                       o_write_enable;
    logic                       o_overflow_flag;
    logic                       o_carry_flag;
    logic                       o_negative_flag;
    logic                       o_zero_flag;
    logic                       o_nz_update;
    logic                       o_divide_by_zero;

    t_div_item   pending_items[$];
    t_div_result expected_results[$];

    int n_in_sent       = 0;
    int n_in_acc        = 0;
    int n_out_acc       = 0;
    int n_out_seen      = 0;
    int n_errors        = 0;
    int n_signed        = 0;
    int n_overflow      = 0;
    int n_div_zero      = 0;
    int n_back_pressure = 0;
    int idle_cycles     = 0;
    int tx_gap          = 0;
    int rx_wait         = 0;
    int hold_left       = 0;
    bit tx_quiet        = 1'b0;
    bit rx_quiet        = 1'b0;
    bit hold_done       = 1'b0;

    cpu_word_divide_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_operation      (i_operation),
        .i_dividend       (i_dividend),
        .i_divisor        (i_divisor),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_packed_result  (o_packed_result),
        .o_write_enable   (o_write_enable),
        .o_overflow_flag  (o_overflow_flag),
        .o_carry_flag     (o_carry_flag),
        .o_negative_flag  (o_negative_flag),
        .o_zero_flag      (o_zero_flag),
        .o_nz_update      (o_nz_update),
        .o_divide_by_zero (o_divide_by_zero)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_div_result predict_divide(
        logic                       op,
        logic [CWDU_DIVIDEND_W-1:0] dvd,
        logic [CWDU_DIVISOR_W-1:0]  dvs
    );
        t_div_result                res;
        logic [CWDU_DIVIDEND_W-1:0] mag_dvd;
        logic [CWDU_DIVIDEND_W-1:0] mag_dvs;
        logic [CWDU_DIVIDEND_W-1:0] quo;
        logic [CWDU_DIVIDEND_W-1:0] rmd;
        logic [CWDU_DIVISOR_W-1:0]  q16;
        logic [CWDU_DIVISOR_W-1:0]  r16;
        logic                       q_neg;
        logic                       ovf;
        res = '0;
        if (dvs == '0) begin
            res.divide_by_zero = 1'b1;
            return res;
        end
        if (op == CWDU_OP_DIVU) begin
            quo = dvd / {16'h0000, dvs};
            rmd = dvd % {16'h0000, dvs};
            ovf = (quo > 32'h0000_ffff);
            q16 = quo[15:0];
            r16 = rmd[15:0];
        end else begin
            // The most negative dividend negates to 2^31, which still fits unsigned.
            mag_dvd = dvd[31] ? (32'h0 - dvd) : dvd;
            mag_dvs = {16'h0000, dvs[15] ? (16'h0 - dvs) : dvs};
            quo = mag_dvd / mag_dvs;
            rmd = mag_dvd % mag_dvs;
            q_neg = dvd[31] ^ dvs[15];
            ovf = q_neg ? (quo > CWDU_QMAX_NEG) : (quo > CWDU_QMAX_POS);
            q16 = quo[15:0];
            r16 = rmd[15:0];
            if (q_neg) begin
                q16 = 16'h0 - q16;
            end
            if (dvd[31]) begin
                r16 = 16'h0 - r16;
            end
        end
        if (ovf) begin
            res.overflow_flag = 1'b1;
            return res;
        end
        res.packed_result = {r16, q16};
        res.write_enable  = 1'b1;
        res.negative_flag = q16[15];
        res.zero_flag     = (q16 == '0);
        res.nz_update     = 1'b1;
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    task automatic push_divide(logic op, logic [31:0] dvd, logic [15:0] dvs);
        t_div_item item;
        item.op       = op;
        item.dividend = dvd;
        item.divisor  = dvs;
        pending_items.push_back(item);
    endtask

    always @(posedge i_clk) begin
        t_div_result want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(predict_divide(i_operation, i_dividend, i_divisor));
                n_in_acc++;
                if (i_operation == CWDU_OP_DIVS) begin
                    n_signed++;
                end
            end
            if (i_valid && o_stall) begin
                n_back_pressure++;
            end
            if (o_valid && !i_stall) begin
                n_out_acc++;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with no item outstanding, expected none, actual %0h",
                             $time, o_packed_result);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("packed_result", want.packed_result, o_packed_result);
                    check_field("write_enable", 32'(want.write_enable), 32'(o_write_enable));
                    check_field("overflow_flag", 32'(want.overflow_flag),
                                32'(o_overflow_flag));
                    check_field("carry_flag", 32'(want.carry_flag), 32'(o_carry_flag));
                    check_field("negative_flag", 32'(want.negative_flag),
                                32'(o_negative_flag));
                    check_field("zero_flag", 32'(want.zero_flag), 32'(o_zero_flag));
                    check_field("nz_update", 32'(want.nz_update), 32'(o_nz_update));
                    check_field("divide_by_zero", 32'(want.divide_by_zero),
                                32'(o_divide_by_zero));
                    if (want.overflow_flag) begin
                        n_overflow++;
                    end
                    if (want.divide_by_zero) begin
                        n_div_zero++;
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, expected_results.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin
        t_div_item item;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && n_in_acc != n_in_sent)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                i_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                item = pending_items.pop_front();
                i_valid     <= 1'b1;
                i_operation <= item.op;
                i_dividend  <= item.dividend;
                i_divisor   <= item.divisor;
                n_in_sent++;
                if ($urandom_range(0, 39) == 0) begin
                    tx_quiet = !tx_quiet;
                end
                tx_gap = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (n_in_acc >= HOLD_AFTER && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (n_out_acc != n_out_seen) begin
                n_out_seen = n_out_acc;
                if ($urandom_range(0, 39) == 0) begin
                    rx_quiet = !rx_quiet;
                end
                rx_wait = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        int                         kind;
        int                         mag_v;
        int                         rm;
        int                         n_total;
        longint                     quo_l;
        longint                     prod_l;
        logic                       op;
        logic                       neg_v;
        logic [CWDU_DIVIDEND_W-1:0] dvd;
        logic [CWDU_DIVISOR_W-1:0]  dvs;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_stall     = 1'b0;
        i_operation = CWDU_OP_DIVU;
        i_dividend  = '0;
        i_divisor   = '0;

        push_divide(CWDU_OP_DIVU, 32'h0000_0064, 16'h0000);
        push_divide(CWDU_OP_DIVS, 32'hffff_ffff, 16'h0000);
        push_divide(CWDU_OP_DIVU, 32'h0000_0000, 16'h0001);
        push_divide(CWDU_OP_DIVU, 32'h0000_0064, 16'h0007);
        push_divide(CWDU_OP_DIVU, 32'h0000_ffff, 16'h0001);
        push_divide(CWDU_OP_DIVU, 32'h0001_0000, 16'h0001);
        push_divide(CWDU_OP_DIVU, 32'hfffe_ffff, 16'hffff);
        push_divide(CWDU_OP_DIVU, 32'hffff_ffff, 16'hffff);
        push_divide(CWDU_OP_DIVS, 32'h8000_0000, 16'hffff);
        push_divide(CWDU_OP_DIVS, 32'h8000_0000, 16'h8000);
        push_divide(CWDU_OP_DIVS, 32'h8000_0000, 16'h0001);
        push_divide(CWDU_OP_DIVS, 32'hffff_8000, 16'h0001);
        push_divide(CWDU_OP_DIVS, 32'h0000_8000, 16'hffff);
        push_divide(CWDU_OP_DIVS, 32'h0000_8000, 16'h0001);
        push_divide(CWDU_OP_DIVS, 32'h0000_7fff, 16'h0001);
        push_divide(CWDU_OP_DIVS, 32'hc000_0000, 16'h8000);
        push_divide(CWDU_OP_DIVS, 32'h3fff_8000, 16'h8000);
        push_divide(CWDU_OP_DIVS, 32'hffff_fff9, 16'h0002);
        push_divide(CWDU_OP_DIVS, 32'h0000_0007, 16'hfffe);
        push_divide(CWDU_OP_DIVS, 32'hffff_fff9, 16'hfffe);
        push_divide(CWDU_OP_DIVS, 32'h0000_0000, 16'hffff);
        push_divide(CWDU_OP_DIVS, 32'hffff_ffff, 16'hffff);
        push_divide(CWDU_OP_DIVS, 32'h7fff_ffff, 16'h7fff);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            kind = $urandom_range(0, 9);
            op   = 1'($urandom_range(0, 1));
            if (kind <= 5) begin
                // Build the dividend from a chosen quotient so that most divides fit;
                // kind 5 puts the quotient just either side of its limit.
                if (op == CWDU_OP_DIVU) begin
                    mag_v  = $urandom_range(1, (1 << $urandom_range(1, 16)) - 1);
                    quo_l  = (kind == 5) ? 65535 + longint'($urandom_range(0, 1))
                                         : longint'($urandom_range(0, 65535));
                    prod_l = quo_l * mag_v + longint'($urandom_range(0, mag_v - 1));
                    dvs    = 16'(mag_v);
                end else begin
                    mag_v = $urandom_range(1, 1 << $urandom_range(0, 15));
                    neg_v = (mag_v == 32768) || ($urandom_range(0, 1) == 1);
                    if (kind == 5) begin
                        quo_l = ($urandom_range(0, 1) == 1)
                              ? 32767 + longint'($urandom_range(0, 1))
                              : -32768 - longint'($urandom_range(0, 1));
                    end else begin
                        quo_l = longint'($urandom_range(0, 65535)) - 32768;
                    end
                    prod_l = quo_l * (neg_v ? -mag_v : mag_v);
                    rm     = $urandom_range(0, mag_v - 1);
                    prod_l = (prod_l < 0 || (prod_l == 0 && $urandom_range(0, 1) == 1))
                           ? prod_l - rm : prod_l + rm;
                    dvs    = neg_v ? 16'(-mag_v) : 16'(mag_v);
                end
                dvd = prod_l[31:0];
            end else if (kind <= 8) begin
                dvd = ($urandom_range(0, 1) == 1) ? $urandom : ($urandom >> $urandom_range(0, 31));
                dvs = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
            end else begin
                case ($urandom_range(0, 6))
                    0:       dvd = 32'h0000_0000;
                    1:       dvd = 32'h0000_0001;
                    2:       dvd = 32'h7fff_ffff;
                    3:       dvd = 32'h8000_0000;
                    4:       dvd = 32'hffff_ffff;
                    5:       dvd = 32'h0000_ffff;
                    default: dvd = 32'hffff_8000;
                endcase
                case ($urandom_range(0, 4))
                    0:       dvs = 16'h0000;
                    1:       dvs = 16'h0001;
                    2:       dvs = 16'h7fff;
                    3:       dvs = 16'h8000;
                    default: dvs = 16'hffff;
                endcase
            end
            push_divide(op, dvd, dvs);
        end
        n_total = pending_items.size();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_in_acc < n_total || expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d divides (%0d signed), of which %0d overflowed and %0d had a zero divisor.",
                 n_in_acc, n_signed, n_overflow, n_div_zero);
        $display("The input was held off for %0d cycles by a full pipeline.", n_back_pressure);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
